// File: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, codes and types of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int DATA_W = 32;

  localparam int GRP = 16;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_UPDATE = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_FULL   = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              upd;
    logic              del;
    logic              rd;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// File: rtl/pal_if.sv
// ----------------------------------------------------------------------------
// pal_if
// Valid/ready channels of the positional array list: operation and result.
// ----------------------------------------------------------------------------
interface pal_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         position;
  logic signed [31:0] item_value;

  modport source (output valid, output kind, output position, output item_value,
                  input ready);
  modport sink (input valid, input kind, input position, input item_value,
                output ready);
endinterface

interface pal_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         entry_count;

  modport source (output valid, output status, output read_value,
                  output entry_count, input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

// File: rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list entry. Takes its left neighbor on insert, its right neighbor on
// delete, the write data on insert or update at its own position.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] q_o,
  output logic [DATA_W-1:0] hit_o
);

  logic [DATA_W-1:0] q_r;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (idx_i == ctl_i.pos);
  assign past_pos = (idx_i > ctl_i.pos);

  always_ff @(posedge clk) begin
    if (ctl_i.ins && past_pos) begin
      q_r <= left_i;
    end else if ((ctl_i.ins || ctl_i.upd) && at_pos) begin
      q_r <= ctl_i.wdata;
    end else if (ctl_i.del && (past_pos || at_pos)) begin
      q_r <= right_i;
    end
  end

  assign q_o   = q_r;
  assign hit_o = (ctl_i.rd && at_pos) ? q_r : '0;

endmodule

// File: rtl/pal_rd_tree.sv
// ----------------------------------------------------------------------------
// pal_rd_tree
// Read collector: ORs the cell hit words in registered groups, then ORs the
// group registers into the final read word.
// ----------------------------------------------------------------------------
module pal_rd_tree
  import pal_pkg::*;
(
  input  logic              clk,
  input  logic              ld_i,
  input  logic [DATA_W-1:0] hit_i [DEPTH],
  output logic [DATA_W-1:0] or_o
);

  logic [DATA_W-1:0] grp_r [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [DATA_W-1:0] grp_nxt;

    always_comb begin
      grp_nxt = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_nxt = grp_nxt | hit_i[g*GRP+k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld_i) begin
        grp_r[g] <= grp_nxt;
      end
    end
  end

  always_comb begin
    or_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      or_o = or_o | grp_r[g];
    end
  end

endmodule

// File: rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit words with insert, update, delete and read at a
// 1-based position and clear, one result word per operation word.
// ----------------------------------------------------------------------------
// Each operation goes from acceptance to its result word through a check at
// acceptance, the execute state in which the whole row of cells shifts or
// writes at once, and the registered read-collector tree into the output
// register. A new operation word is accepted while the last result word still
// waits in the output register; the block stalls only when a second result is
// ready and the first has not been taken.
module positional_array_list
  import pal_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  pal_in_if.sink   in_ch,
  pal_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TREE = 3'b100
  } state_t;

  typedef struct packed {
    logic ins;
    logic upd;
    logic del;
    logic rd;
    logic clr;
  } act_t;

  state_t            state_r, state_nxt;
  act_t              act_r, act_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r;
  status_t           sts_r, sts_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r;
  status_t           out_sts_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [7:0]        out_cnt_r;

  logic              in_acc;
  logic              exec;
  logic              out_free;
  logic              out_load;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  pos_m1;
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_q   [DEPTH];
  logic [DATA_W-1:0] cell_hit [DEPTH];
  logic [DATA_W-1:0] tree_or;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign exec     = (state_r == S_EXEC);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_TREE) && out_free;

  assign cnt_w  = CMP_W'(count_r);
  assign pos_w  = CMP_W'(in_ch.position);
  assign pos_m1 = pos_w - CMP_W'(1);

  // operation check at acceptance
  always_comb begin
    act_nxt = '0;
    sts_nxt = STS_DONE;
    pos_nxt = IDX_W'(pos_m1);
    case (in_ch.kind)
      KIND_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          sts_nxt = STS_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          sts_nxt = STS_BADPOS;
        end else begin
          act_nxt.ins = 1'b1;
        end
      end
      KIND_UPDATE, KIND_DELETE, KIND_READ: begin
        if (count_r == '0) begin
          sts_nxt = STS_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          sts_nxt = STS_BADPOS;
        end else begin
          act_nxt.upd = (in_ch.kind == KIND_UPDATE);
          act_nxt.del = (in_ch.kind == KIND_DELETE);
          act_nxt.rd  = (in_ch.kind == KIND_READ);
        end
      end
      KIND_CLEAR: begin
        act_nxt.clr = 1'b1;
      end
      default: begin
        act_nxt = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_TREE;
      end
      S_TREE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (exec) begin
      if (act_r.ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (act_r.del) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (act_r.clr) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      act_r       <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (in_acc) begin
        act_r <= act_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= pos_nxt;
      val_r <= in_ch.item_value;
      sts_r <= sts_nxt;
    end
    if (out_load) begin
      out_sts_r <= sts_r;
      out_rd_r  <= tree_or;
      out_cnt_r <= cnt_w[7:0];
    end
  end

  assign ctl.ins   = exec && act_r.ins;
  assign ctl.upd   = exec && act_r.upd;
  assign ctl.del   = exec && act_r.del;
  assign ctl.rd    = exec && act_r.rd;
  assign ctl.pos   = pos_r;
  assign ctl.wdata = val_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end

    pal_cell u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .idx_i   (IDX_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[i]),
      .hit_o   (cell_hit[i])
    );
  end

  pal_rd_tree u_rd_tree (
    .clk   (clk),
    .ld_i  (exec),
    .hit_i (cell_hit),
    .or_o  (tree_or)
  );

  assign in_ch.ready        = rst_n && (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_sts_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.entry_count = out_cnt_r;

  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted word did not start execution");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    exec && sts_r != STS_DONE |=> $stable(count_r))
    else $error("failed operation changed the entry count");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sts_r != STS_DONE |-> out_rd_r == '0)
    else $error("read word nonzero on error status");

  a_tree_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TREE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result word not loaded");

endmodule
